/* hdl/lcr_pkg.sv */
// lcr_pkg: shared widths, register indexes, mode codes and the command and
// status structs of the led current regulator.
// No dependencies; used by every module of the block.
package lcr_pkg;

    // field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int CUR_W      = 12;
    localparam int DUTY_W     = 10;
    localparam int MODE_W     = 3;
    localparam int PGAIN_W    = 16;
    localparam int GAIN_W     = 24;
    localparam int SCALE_W    = 12;
    localparam int STEP_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // datapath widths
    localparam int ERR_W      = CUR_W + 1;
    localparam int FRAC_W     = 16;
    localparam int PROP_SHIFT = 8;
    localparam int PROP_ROUND = (1 << PROP_SHIFT) - 1;
    localparam int MUL_A_W    = GAIN_W;
    localparam int MUL_B_W    = 17;
    localparam int PROD_W     = MUL_A_W + 1 + MUL_B_W;
    localparam int ACC_W      = PROD_W + 1;

    // largest value the current scaling can produce
    localparam int MEAS_MAX   = (((1 << SAMPLE_W) - 1) * ((1 << SCALE_W) - 1)) >> FRAC_W;

    // control modes
    localparam logic [MODE_W-1:0] MODE_OPEN = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BANG = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INC  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PROP = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PID  = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN_Q8  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PID_P_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PID_I_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PID_D_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_SCALE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INC_STEP      = 3'd6;

    // register reset values
    localparam logic [MODE_W-1:0]  RST_CONTROL_MODE  = MODE_PID;
    localparam logic [PGAIN_W-1:0] RST_PROP_GAIN_Q8  = 16'd256;
    localparam logic [GAIN_W-1:0]  RST_PID_P_GAIN    = 24'd65536;
    localparam logic [GAIN_W-1:0]  RST_PID_I_GAIN    = 24'd0;
    localparam logic [GAIN_W-1:0]  RST_PID_D_GAIN    = 24'd0;
    localparam logic [SCALE_W-1:0] RST_CURRENT_SCALE = 12'd1500;
    localparam logic [STEP_W-1:0]  RST_INC_STEP      = 8'd1;

    // operand pair for the shared multiplier
    typedef enum logic [2:0] {
        SEL_SCALE = 3'd0,
        SEL_PROP  = 3'd1,
        SEL_P     = 3'd2,
        SEL_I     = 3'd3,
        SEL_D     = 3'd4
    } mul_sel_t;

    // accumulator operation
    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2,
        ACC_SUB  = 2'd3
    } acc_op_t;

    typedef struct packed {
        logic     capture;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     meas_load;
        logic     int_update;
        acc_op_t  acc_op;
        logic     last_update;
        logic     finish;
    } lcr_cmd_t;

    typedef struct packed {
        logic mode_pid;
        logic mode_prop;
    } lcr_status_t;

endpackage

/* hdl/lcr_mul.sv */
// lcr_mul: shared registered multiplier, unsigned gain times signed operand.
// Depends on lcr_pkg.
module lcr_mul (
    input  logic                                clk,
    input  logic                                en,
    input  logic [lcr_pkg::MUL_A_W-1:0]         a,
    input  logic signed [lcr_pkg::MUL_B_W-1:0]  b,
    output logic signed [lcr_pkg::PROD_W-1:0]   prod
);
    import lcr_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    // a is zero extended, so the product is signed
    assign prod_next = $signed({1'b0, a}) * b;

    // product register, held when not enabled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

/* hdl/lcr_datapath.sv */
// lcr_datapath: configuration registers, scaling, error, integrator,
// accumulator, duty level update and result registers.
// Depends on lcr_pkg and lcr_mul.
module lcr_datapath #(
    parameter int DUTY_LIMIT = 1023
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [lcr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lcr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [lcr_pkg::SAMPLE_W-1:0]      adc_sample,
    input  logic [lcr_pkg::CUR_W-1:0]         target_current,
    input  lcr_pkg::lcr_cmd_t                 cmd,
    output lcr_pkg::lcr_status_t              status,
    output logic [lcr_pkg::DUTY_W-1:0]        duty_cycle,
    output logic [lcr_pkg::CUR_W-1:0]         measured_current_ma
);
    import lcr_pkg::*;

    localparam int LIMIT_W = $clog2(DUTY_LIMIT + 1);
    localparam int INT_W   = LIMIT_W + 1;
    localparam int ISUM_W  = ((INT_W > ERR_W) ? INT_W : ERR_W) + 1;
    localparam int LVL_W   = ACC_W - FRAC_W + 1;

    localparam logic signed [ISUM_W-1:0] ILIM_POS = ISUM_W'(DUTY_LIMIT);
    localparam logic signed [ISUM_W-1:0] ILIM_NEG = ISUM_W'(-DUTY_LIMIT);
    localparam logic signed [LVL_W-1:0]  LVL_LIM  = LVL_W'(DUTY_LIMIT);

    // configuration
    logic [MODE_W-1:0]  mode_reg;
    logic [PGAIN_W-1:0] prop_gain_reg;
    logic [GAIN_W-1:0]  p_gain_reg;
    logic [GAIN_W-1:0]  i_gain_reg;
    logic [GAIN_W-1:0]  d_gain_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [STEP_W-1:0]  step_reg;

    // item and working registers
    logic [SAMPLE_W-1:0]       sample_reg;
    logic [CUR_W-1:0]          target_reg;
    logic [CUR_W-1:0]          meas_reg;
    logic [CUR_W-1:0]          meas_next;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [INT_W-1:0]   int_reg;
    logic signed [INT_W-1:0]   int_next;
    logic [CUR_W-1:0]          last_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic [LIMIT_W-1:0]        duty_reg;
    logic [LIMIT_W-1:0]        duty_next;
    logic [CUR_W-1:0]          out_meas_reg;

    // multiplier
    logic [MUL_A_W-1:0]        mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic signed [ERR_W-1:0]   meas_diff;
    logic signed [ISUM_W-1:0]  int_sum;
    logic signed [PROD_W-1:0]  prop_adj;
    logic signed [LVL_W-1:0]   prop_change;
    logic signed [LVL_W-1:0]   pid_change;
    logic signed [LVL_W-1:0]   duty_ext;
    logic signed [LVL_W-1:0]   level;
    logic                      err_pos;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= RST_CONTROL_MODE;
            prop_gain_reg <= RST_PROP_GAIN_Q8;
            p_gain_reg    <= RST_PID_P_GAIN;
            i_gain_reg    <= RST_PID_I_GAIN;
            d_gain_reg    <= RST_PID_D_GAIN;
            scale_reg     <= RST_CURRENT_SCALE;
            step_reg      <= RST_INC_STEP;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CONTROL_MODE:  mode_reg      <= cfg_wdata[MODE_W-1:0];
                REG_PROP_GAIN_Q8:  prop_gain_reg <= cfg_wdata[PGAIN_W-1:0];
                REG_PID_P_GAIN:    p_gain_reg    <= cfg_wdata[GAIN_W-1:0];
                REG_PID_I_GAIN:    i_gain_reg    <= cfg_wdata[GAIN_W-1:0];
                REG_PID_D_GAIN:    d_gain_reg    <= cfg_wdata[GAIN_W-1:0];
                REG_CURRENT_SCALE: scale_reg     <= cfg_wdata[SCALE_W-1:0];
                REG_INC_STEP:      step_reg      <= cfg_wdata[STEP_W-1:0];
                default:           ;
            endcase
        end
    end

    assign status.mode_pid  = (mode_reg == MODE_PID);
    assign status.mode_prop = (mode_reg == MODE_PROP);

    // measurement change since the last pid step
    assign meas_diff = $signed({1'b0, meas_reg}) - $signed({1'b0, last_reg});

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            SEL_SCALE:
            begin
                mul_a = MUL_A_W'(scale_reg);
                mul_b = $signed(MUL_B_W'(sample_reg));
            end
            SEL_PROP:
            begin
                mul_a = MUL_A_W'(prop_gain_reg);
                mul_b = MUL_B_W'(err_reg);
            end
            SEL_P:
            begin
                mul_a = p_gain_reg;
                mul_b = MUL_B_W'(err_reg);
            end
            SEL_I:
            begin
                mul_a = i_gain_reg;
                mul_b = MUL_B_W'(int_reg);
            end
            SEL_D:
            begin
                mul_a = d_gain_reg;
                mul_b = MUL_B_W'(meas_diff);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    lcr_mul u_mul (
        .clk  (clk),
        .en   (cmd.mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // measured current and error from the scaling product
    assign meas_next = prod[FRAC_W +: CUR_W];
    assign err_next  = $signed({1'b0, target_reg}) - $signed({1'b0, meas_next});

    // integrator in whole milliamps, clamped to the duty limit
    assign int_sum = ISUM_W'(int_reg) + ISUM_W'(err_reg);

    always_comb
    begin
        priority if (int_sum > ILIM_POS)
        begin
            int_next = INT_W'(ILIM_POS);
        end
        else if (int_sum < ILIM_NEG)
        begin
            int_next = INT_W'(ILIM_NEG);
        end
        else
        begin
            int_next = INT_W'(int_sum);
        end
    end

    // p + i - d accumulation
    always_comb
    begin
        unique case (cmd.acc_op)
            ACC_HOLD: acc_next = acc_reg;
            ACC_LOAD: acc_next = ACC_W'(prod);
            ACC_ADD:  acc_next = acc_reg + ACC_W'(prod);
            ACC_SUB:  acc_next = acc_reg - ACC_W'(prod);
            default:  acc_next = acc_reg;
        endcase
    end

    // proportional change truncates toward zero, pid change floors
    assign prop_adj    = prod[PROD_W-1] ? (prod + PROD_W'(PROP_ROUND)) : prod;
    assign prop_change = LVL_W'($signed(prop_adj[PROD_W-1:PROP_SHIFT]));
    assign pid_change  = LVL_W'($signed(acc_reg[ACC_W-1:FRAC_W]));
    assign duty_ext    = $signed(LVL_W'(duty_reg));
    assign err_pos     = !err_reg[ERR_W-1] && (err_reg != '0);

    // new level per mode
    always_comb
    begin
        unique case (mode_reg)
            MODE_BANG: level = err_pos ? LVL_LIM : '0;
            MODE_INC:  level = err_pos ? (duty_ext + $signed(LVL_W'(step_reg)))
                                       : (duty_ext - $signed(LVL_W'(step_reg)));
            MODE_PROP: level = duty_ext + prop_change;
            MODE_PID:  level = duty_ext + pid_change;
            default:   level = duty_ext;
        endcase
    end

    // saturate to 0..limit
    always_comb
    begin
        priority if (level < 0)
        begin
            duty_next = '0;
        end
        else if (level > LVL_LIM)
        begin
            duty_next = LIMIT_W'(DUTY_LIMIT);
        end
        else
        begin
            duty_next = LIMIT_W'(level);
        end
    end

    // item capture and working values
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= adc_sample;
            target_reg <= target_current;
        end
        if (cmd.meas_load)
        begin
            meas_reg <= meas_next;
            err_reg  <= err_next;
        end
        acc_reg <= acc_next;
        if (cmd.finish)
        begin
            out_meas_reg <= meas_reg;
        end
    end

    // kept control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_reg  <= '0;
            last_reg <= '0;
            duty_reg <= '0;
        end
        else
        begin
            if (cmd.int_update)
            begin
                int_reg <= int_next;
            end
            if (cmd.last_update)
            begin
                last_reg <= meas_reg;
            end
            if (cmd.finish)
            begin
                duty_reg <= duty_next;
            end
        end
    end

    assign duty_cycle          = DUTY_W'(duty_reg);
    assign measured_current_ma = out_meas_reg;

endmodule

/* hdl/lcr_ctrl.sv */
// lcr_ctrl: sequencer of the led current regulator, steps the datapath
// through scaling and the mode update and owns the handshakes.
// Depends on lcr_pkg.
module lcr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  lcr_pkg::lcr_status_t  status,
    output lcr_pkg::lcr_cmd_t     cmd
);
    import lcr_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_MEAS = 9'b000000010,
        ST_ERR  = 9'b000000100,
        ST_PROP = 9'b000001000,
        ST_P    = 9'b000010000,
        ST_I    = 9'b000100000,
        ST_D    = 9'b001000000,
        ST_DACC = 9'b010000000,
        ST_FIN  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.mul_sel    = SEL_SCALE;
        cmd.acc_op     = ACC_HOLD;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MEAS;
                end
            end
            ST_MEAS:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = SEL_SCALE;
                state_next  = ST_ERR;
            end
            ST_ERR:
            begin
                cmd.meas_load = 1'b1;
                priority if (status.mode_pid)
                begin
                    state_next = ST_P;
                end
                else if (status.mode_prop)
                begin
                    state_next = ST_PROP;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_PROP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = SEL_PROP;
                state_next  = ST_FIN;
            end
            ST_P:
            begin
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = SEL_P;
                cmd.int_update = 1'b1;
                state_next     = ST_I;
            end
            ST_I:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = SEL_I;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_D;
            end
            ST_D:
            begin
                cmd.mul_en      = 1'b1;
                cmd.mul_sel     = SEL_D;
                cmd.acc_op      = ACC_ADD;
                cmd.last_update = 1'b1;
                state_next      = ST_DACC;
            end
            ST_DACC:
            begin
                cmd.acc_op = ACC_SUB;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // wait for the result register to be free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hdl/led_current_regulator_top.sv */
// LED current regulator. Each item is one ADC sample and a target current; the block
// scales the sample to milliamps and updates a kept PWM duty level in the selected
// mode, giving one result item per input item. One multiplier is shared by the scaling
// and every gain product, one product per cycle, so the cost of an item depends on the
// mode, as PID mode steps through more states than proportional mode, and that through
// more than open loop, bang-bang and incremental modes; the next item is taken once
// the current one has finished. A finished result waits in the output register while
// the next item is accepted; an unaccepted result holds the following item in its last
// step. Configuration is written through cfg_wr_en, cfg_index and cfg_wdata; the user
// must write it only while idle, which the block itself does not enforce.
// Depends on lcr_pkg, lcr_ctrl, lcr_datapath and lcr_mul.
module led_current_regulator_top #(
    parameter int DUTY_LIMIT = 1023
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [lcr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lcr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [lcr_pkg::SAMPLE_W-1:0]      adc_sample,
    input  logic [lcr_pkg::CUR_W-1:0]         target_current,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [lcr_pkg::DUTY_W-1:0]        duty_cycle,
    output logic [lcr_pkg::CUR_W-1:0]         measured_current_ma
);
    import lcr_pkg::*;

    lcr_cmd_t    cmd;
    lcr_status_t status;

    // sequencer
    lcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    lcr_datapath #(
        .DUTY_LIMIT (DUTY_LIMIT)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .adc_sample          (adc_sample),
        .target_current      (target_current),
        .cmd                 (cmd),
        .status              (status),
        .duty_cycle          (duty_cycle),
        .measured_current_ma (measured_current_ma)
    );

    // one item at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in progress");

    // result duty never beyond the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(duty_cycle) <= DUTY_LIMIT))
    else $error("duty level beyond limit");

    // scaled current stays within the range of the scaling
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(measured_current_ma) <= MEAS_MAX))
    else $error("measured current beyond scaling range");

endmodule

/* test/lcr_regulation_checker.sv */
// lcr_regulation_checker: watches the config port and both item channels of the
// led current regulator, predicts each result item and compares it field by field.
// Depends on lcr_pkg; instantiated beside the block by tb_led_current_regulator_top.
module lcr_regulation_checker #(
    parameter int DUTY_LIMIT = 1023
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [lcr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lcr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [lcr_pkg::SAMPLE_W-1:0]      adc_sample,
    input  logic [lcr_pkg::CUR_W-1:0]         target_current,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [lcr_pkg::DUTY_W-1:0]        duty_cycle,
    input  logic [lcr_pkg::CUR_W-1:0]         measured_current_ma,
    output logic                              busy,
    output int                                mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import lcr_pkg::*;

    // keep the log short when the block is badly off
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [CUR_W-1:0]  current;
    } regulator_result_t;

    // shadow of the configuration registers
    logic [MODE_W-1:0]  ctl_mode;
    logic [PGAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0]  kp_gain;
    logic [GAIN_W-1:0]  ki_gain;
    logic [GAIN_W-1:0]  kd_gain;
    logic [SCALE_W-1:0] cur_scale;
    logic [STEP_W-1:0]  step_size;

    // control loop state, signed and wide
    longint duty_level;
    longint int_acc;
    longint last_pos_fx;

    regulator_result_t expected_results[$];

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // one control step: scale the sample, update the duty level
    function automatic regulator_result_t regulate(input logic [SAMPLE_W-1:0] sample,
                                                   input logic [CUR_W-1:0] target);
        longint meas;
        longint tgt;
        longint err;
        longint level;
        longint lim;
        longint err_fx;
        longint pos_fx;
        longint lim_fx;
        longint p_term;
        longint i_term;
        longint d_term;
        regulator_result_t res;

        lim   = DUTY_LIMIT;
        meas  = (longint'(sample) * longint'(cur_scale)) >>> FRAC_W;
        tgt   = longint'(target);
        err   = tgt - meas;
        level = duty_level;

        case (ctl_mode)
            MODE_BANG:
            begin
                level = (meas < tgt) ? lim : 0;
            end
            MODE_INC:
            begin
                if (meas < tgt)
                    level = level + longint'(step_size);
                else
                    level = level - longint'(step_size);
            end
            MODE_PROP:
            begin
                // signed division truncates toward zero
                level = level + (longint'(prop_gain) * err) / 256;
            end
            MODE_PID:
            begin
                err_fx = err <<< FRAC_W;
                pos_fx = meas <<< FRAC_W;
                lim_fx = lim <<< FRAC_W;
                p_term = (longint'(kp_gain) * err_fx) >>> FRAC_W;
                int_acc = int_acc + err_fx;
                if (int_acc > lim_fx)
                    int_acc = lim_fx;
                else if (int_acc < -lim_fx)
                    int_acc = -lim_fx;
                i_term = (longint'(ki_gain) * int_acc) >>> FRAC_W;
                // derivative on the measurement, not the error
                d_term = (longint'(kd_gain) * (pos_fx - last_pos_fx)) >>> FRAC_W;
                last_pos_fx = pos_fx;
                level = level + ((p_term + i_term - d_term) >>> FRAC_W);
            end
            default:
            begin
                // open loop and spare codes hold the level
            end
        endcase

        if (level < 0)
            level = 0;
        else if (level > lim)
            level = lim;
        duty_level = level;

        res.duty    = DUTY_W'(level);
        res.current = CUR_W'(meas);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        regulator_result_t want;

        if (!rst_n)
        begin
            ctl_mode    = RST_CONTROL_MODE;
            prop_gain   = RST_PROP_GAIN_Q8;
            kp_gain     = RST_PID_P_GAIN;
            ki_gain     = RST_PID_I_GAIN;
            kd_gain     = RST_PID_D_GAIN;
            cur_scale   = RST_CURRENT_SCALE;
            step_size   = RST_INC_STEP;
            duty_level  = 0;
            int_acc     = 0;
            last_pos_fx = 0;
            expected_results.delete();
            busy <= 1'b0;
        end
        else
        begin
            // register writes, masked to each register's width
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_CONTROL_MODE:  ctl_mode  = cfg_wdata[MODE_W-1:0];
                    REG_PROP_GAIN_Q8:  prop_gain = cfg_wdata[PGAIN_W-1:0];
                    REG_PID_P_GAIN:    kp_gain   = cfg_wdata[GAIN_W-1:0];
                    REG_PID_I_GAIN:    ki_gain   = cfg_wdata[GAIN_W-1:0];
                    REG_PID_D_GAIN:    kd_gain   = cfg_wdata[GAIN_W-1:0];
                    REG_CURRENT_SCALE: cur_scale = cfg_wdata[SCALE_W-1:0];
                    REG_INC_STEP:      step_size = cfg_wdata[STEP_W-1:0];
                    default:           ;
                endcase
            end

            // result item against the oldest expectation
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("result with nothing expected: duty %0d current %0d",
                                              duty_cycle, measured_current_ma));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (duty_cycle !== want.duty)
                        report_mismatch($sformatf("duty_cycle got %0d want %0d",
                                                  duty_cycle, want.duty));
                    if (measured_current_ma !== want.current)
                        report_mismatch($sformatf("measured_current_ma got %0d want %0d",
                                                  measured_current_ma, want.current));
                end
            end

            // accepted input item
            if (in_valid && in_ready)
                expected_results.push_back(regulate(adc_sample, target_current));

            busy <= (expected_results.size() != 0);
        end
    end

endmodule

/* test/tb_led_current_regulator_top.sv */
// tb_led_current_regulator_top: clock, reset, config writes and item stimulus for
// the led current regulator, with random idling on both channels and the verdict.
// Depends on lcr_pkg, led_current_regulator_top and lcr_regulation_checker.
module tb_led_current_regulator_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lcr_pkg::*;

    localparam int DUTY_LIMIT      = 1023;
    localparam int RUN_LIMIT       = 400000;
    localparam int PHASES          = 20;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int QUIET_PHASES    = 3;
    localparam int DRAIN_CYCLES    = 16;

    // index past the register list, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    // mode codes with no meaning, held like open loop
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    localparam logic [PGAIN_W-1:0]  PGAIN_MAX  = '1;
    localparam logic [GAIN_W-1:0]   GAIN_MAX   = '1;
    localparam logic [SCALE_W-1:0]  SCALE_MAX  = '1;
    localparam logic [STEP_W-1:0]   STEP_MAX   = '1;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
    localparam logic [CUR_W-1:0]    CUR_MAX    = '1;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [SAMPLE_W-1:0]   adc_sample = '0;
    logic [CUR_W-1:0]      target_current = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b1;
    logic [DUTY_W-1:0]     duty_cycle;
    logic [CUR_W-1:0]      measured_current_ma;

    logic                  busy;
    int                    mismatch_count;
    int                    cycle_count = 0;
    bit                    idle_on = 1'b0;
    logic [SCALE_W-1:0]    scale_setting = RST_CURRENT_SCALE;

    led_current_regulator_top #(
        .DUTY_LIMIT(DUTY_LIMIT)
    ) u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .adc_sample          (adc_sample),
        .target_current      (target_current),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .duty_cycle          (duty_cycle),
        .measured_current_ma (measured_current_ma)
    );

    lcr_regulation_checker #(
        .DUTY_LIMIT(DUTY_LIMIT)
    ) u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .adc_sample          (adc_sample),
        .target_current      (target_current),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .duty_cycle          (duty_cycle),
        .measured_current_ma (measured_current_ma),
        .busy                (busy),
        .mismatch_count      (mismatch_count)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side stalls in short bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // present one item and hold it until accepted
    task automatic send_item(input logic [SAMPLE_W-1:0] sample, input logic [CUR_W-1:0] target);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        adc_sample     <= sample;
        target_current <= target;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // drop valid and wait for every expected result
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (busy);
    endtask

    // one register write, sometimes with junk above the register width
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value,
                             input int width);
        logic [CFG_DATA_W-1:0] keep;
        logic [CFG_DATA_W-1:0] junk;
        keep = (CFG_DATA_W'(1) << width) - CFG_DATA_W'(1);
        junk = CFG_DATA_W'($urandom());
        if ($urandom_range(0, 3) == 0)
            value = (value & keep) | (junk & ~keep);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    // full register set, written while the block is idle
    task automatic set_config(input logic [MODE_W-1:0] mode, input logic [PGAIN_W-1:0] pg,
                              input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                              input logic [GAIN_W-1:0] kd, input logic [SCALE_W-1:0] sc,
                              input logic [STEP_W-1:0] st);
        wait_idle();
        write_cfg(REG_CONTROL_MODE, CFG_DATA_W'(mode), MODE_W);
        write_cfg(REG_PROP_GAIN_Q8, CFG_DATA_W'(pg), PGAIN_W);
        write_cfg(REG_PID_P_GAIN, kp, GAIN_W);
        write_cfg(REG_PID_I_GAIN, ki, GAIN_W);
        write_cfg(REG_PID_D_GAIN, kd, GAIN_W);
        write_cfg(REG_CURRENT_SCALE, CFG_DATA_W'(sc), SCALE_W);
        write_cfg(REG_INC_STEP, CFG_DATA_W'(st), STEP_W);
        if ($urandom_range(0, 2) == 0)
            write_cfg(REG_UNUSED, CFG_DATA_W'($urandom()), CFG_DATA_W);
        cfg_wr_en <= 1'b0;
        scale_setting = sc;
    endtask

    // random settings: extremes, all zero, tame loop gains or full range
    task automatic random_config();
        logic [MODE_W-1:0]  mode;
        logic [PGAIN_W-1:0] pg;
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki;
        logic [GAIN_W-1:0]  kd;
        logic [SCALE_W-1:0] sc;
        logic [STEP_W-1:0]  st;
        int                 shape;
        shape = $urandom_range(0, 9);
        if ($urandom_range(0, 6) == 0)
            mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        else
            mode = MODE_W'($urandom_range(MODE_OPEN, MODE_PID));
        pg = PGAIN_W'($urandom());
        kp = GAIN_W'($urandom());
        ki = GAIN_W'($urandom());
        kd = GAIN_W'($urandom());
        sc = SCALE_W'($urandom());
        st = STEP_W'($urandom());
        if (shape == 0)
        begin
            pg = PGAIN_MAX;
            kp = GAIN_MAX;
            ki = GAIN_MAX;
            kd = GAIN_MAX;
            sc = SCALE_MAX;
            st = STEP_MAX;
        end
        else if (shape == 1)
        begin
            pg = '0;
            kp = '0;
            ki = '0;
            kd = '0;
            sc = '0;
            st = '0;
        end
        else if (shape < 7)
        begin
            pg = PGAIN_W'($urandom_range(0, 1023));
            kp = GAIN_W'($urandom_range(0, 1 << 18));
            ki = GAIN_W'($urandom_range(0, 1 << 12));
            kd = GAIN_W'($urandom_range(0, 1 << 16));
            sc = SCALE_W'($urandom_range(1000, 4095));
            st = STEP_W'($urandom_range(0, 15));
        end
        set_config(mode, pg, kp, ki, kd, sc, st);
    endtask

    // mostly targets close to the measured current, some uniform, some extremes
    task automatic random_item();
        logic [SAMPLE_W-1:0] sample;
        logic [CUR_W-1:0]    target;
        int                  near;
        sample = SAMPLE_W'($urandom());
        target = CUR_W'($urandom());
        case ($urandom_range(0, 9))
            0:
            begin
                sample = $urandom_range(0, 1) ? SAMPLE_MAX : '0;
                target = $urandom_range(0, 1) ? CUR_MAX : '0;
            end
            1, 2, 3:
            begin
                // uniform over both fields
            end
            default:
            begin
                near = (int'(sample) * int'(scale_setting)) >>> FRAC_W;
                near = near + int'($urandom_range(0, 40)) - 20;
                if (near < 0)
                    near = 0;
                else if (near > int'(CUR_MAX))
                    near = int'(CUR_MAX);
                target = CUR_W'(near);
            end
        endcase
        send_item(sample, target);
    endtask

    // stimulus and verdict
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pid at reset settings, unity proportional gain
        send_item('0, '0);
        send_item(SAMPLE_MAX, CUR_MAX);
        send_item(SAMPLE_MAX, '0);
        send_item('0, CUR_MAX);
        send_item(16'h5A5A, 12'hA5A);

        // open loop holds the level
        set_config(MODE_OPEN, RST_PROP_GAIN_Q8, RST_PID_P_GAIN, '0, '0, SCALE_MAX, RST_INC_STEP);
        send_item(SAMPLE_MAX, CUR_MAX);
        send_item('0, '0);

        // bang-bang: below target, above, and exactly equal
        set_config(MODE_BANG, RST_PROP_GAIN_Q8, RST_PID_P_GAIN, '0, '0, SCALE_MAX, RST_INC_STEP);
        send_item('0, CUR_MAX);
        send_item(SAMPLE_MAX, '0);
        send_item(SAMPLE_MAX, 12'd4094);

        // incremental: climb into the top clamp, equal steps down
        set_config(MODE_INC, RST_PROP_GAIN_Q8, RST_PID_P_GAIN, '0, '0, SCALE_MAX, STEP_MAX);
        repeat (5) send_item('0, CUR_MAX);
        repeat (2) send_item(SAMPLE_MAX, 12'd4094);

        // proportional: truncation toward zero on small errors, both clamps
        set_config(MODE_PROP, 16'd385, RST_PID_P_GAIN, '0, '0, SCALE_MAX, RST_INC_STEP);
        send_item('0, CUR_MAX);
        send_item(SAMPLE_MAX, 12'd4093);
        send_item(SAMPLE_MAX, CUR_MAX);
        set_config(MODE_PROP, PGAIN_MAX, RST_PID_P_GAIN, '0, '0, SCALE_MAX, RST_INC_STEP);
        send_item(SAMPLE_MAX, '0);

        // pid with every gain at full scale, integrator into its clamp
        set_config(MODE_PID, PGAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, SCALE_MAX, STEP_MAX);
        send_item('0, CUR_MAX);
        send_item(SAMPLE_MAX, '0);
        send_item('0, '0);

        // spare mode code holds the level
        set_config(MODE_SPARE_HI, PGAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, SCALE_MAX, STEP_MAX);
        send_item(SAMPLE_MAX, CUR_MAX);

        // random phases, the last few without idling
        for (int ph = 0; ph < PHASES; ph++)
        begin
            idle_on = (ph < PHASES - QUIET_PHASES) && ($urandom_range(0, 3) != 0);
            random_config();
            repeat (ITEMS_PER_PHASE) random_item();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* led_current_regulator_top.f */
hdl/lcr_pkg.sv
hdl/lcr_mul.sv
hdl/lcr_datapath.sv
hdl/lcr_ctrl.sv
hdl/led_current_regulator_top.sv
test/lcr_regulation_checker.sv
test/tb_led_current_regulator_top.sv
